// ===== hdl/chunk_reassembly_engine_core_assert.svh =====
// assertion macros for the chunk reassembly engine
`ifndef CHUNK_REASSEMBLY_ENGINE_CORE_ASSERT_SVH
`define CHUNK_REASSEMBLY_ENGINE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define CRE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cre assertion failed");
// checked at every edge, reset included
`define CRE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("cre assertion failed");
`else
`define CRE_ASSERT(lbl, clk, rstn, prop)
`define CRE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hdl/cre_pkg.sv =====
`default_nettype none

package cre_pkg;

  localparam int PayloadBytes = 16384;
  localparam int MaxChunks    = 256;
  localparam int AddrW        = $clog2(PayloadBytes);
  localparam int IdxW         = $clog2(MaxChunks);
  localparam int CntW         = 9;
  localparam int LenW         = 15;

  typedef enum logic [1:0] {
    ReqHeader,
    ReqPair,
    ReqReset,
    ReqRead
  } req_e;

  typedef enum logic [2:0] {
    StsOk,
    StsBadHeader,
    StsDuplicate,
    StsTooLarge,
    StsBadDigit,
    StsNoChunk,
    StsReadRefused,
    StsCommitted
  } status_e;

  // bit 4 set when the character is not a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'h10;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b0, ch[3:0]};
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      r = {1'b0, 4'(ch[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/chunk_reassembly_engine_core.sv =====
// Chunk reassembly engine. Each request gives exactly one result. The payload
// store and the seen map are single-port synchronous memories with registered
// read data. The seen map entry of a header is read as the request is
// accepted. A read request reads the payload store in StExec, and its result
// is formed from the registered byte in StRead. A reset request, and a header
// whose total differs from the running transfer, first pass through StWipe,
// where the seen map is cleared one entry per cycle before the result is
// formed. A result waits in an output register, so the next request can be
// accepted while it is still stalled; a request only finishes once the output
// register is free. After reset the block stalls its input in StClear while
// it clears the payload store one byte per cycle, and the seen map alongside
// it.
`default_nettype none
`include "chunk_reassembly_engine_core_assert.svh"

module chunk_reassembly_engine_core
  import cre_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [8:0]  chunk_index_i,
  input  wire logic [8:0]  chunk_total_i,
  input  wire logic [15:0] byte_offset_i,
  input  wire logic [8:0]  hex_char_count_i,
  input  wire logic [7:0]  hex_high_char_i,
  input  wire logic [7:0]  hex_low_char_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [8:0]       chunks_received_o,
  output logic [8:0]       chunks_expected_o,
  output logic [14:0]      payload_length_o,
  output logic             transfer_complete_o,
  output logic             transfer_restarted_o,
  output logic [7:0]       read_byte_o
);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StExec,
    StWipe,
    StRead
  } state_e;

  state_e            state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [CntW-1:0]   seen_total_q, seen_total_d;
  logic [CntW-1:0]   exp_q, exp_d;
  logic [LenW-1:0]   len_q, len_d;
  logic              open_q, open_d;
  logic [IdxW-1:0]   open_idx_q, open_idx_d;
  logic [LenW-1:0]   wp_q, wp_d;
  logic [7:0]        pairs_q, pairs_d;
  logic [LenW-1:0]   cend_q, cend_d;
  logic              out_valid_q, out_valid_d;
  logic              rd_ok_q, rd_ok_d;
  logic              wiped_q, wiped_d;

  // request held for execution
  req_e              req_q;
  logic [8:0]        idx_q, total_q, count_q;
  logic [15:0]       off_q;
  logic [7:0]        hi_q, lo_q;

  // result register
  status_e           status_q, status_d;
  logic              restarted_q, restarted_d;
  logic [7:0]        rbyte_q, rbyte_d;
  logic [CntW-1:0]   res_seen_q;
  logic [CntW-1:0]   res_exp_q;
  logic [LenW-1:0]   res_len_q;
  logic              res_done_q;
  logic              out_load;

  // payload store
  logic [7:0]        payload_mem [PayloadBytes];
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;
  logic [7:0]        rd_q;

  // seen map
  logic              seen_mem [MaxChunks];
  logic              seen_we;
  logic [IdxW-1:0]   seen_waddr;
  logic              seen_wdata;
  logic              seen_rd_q;

  logic              accept;
  logic              out_free;
  logic              hdr_bad, restart, seen_hit, too_large, commit;
  logic              need_wipe;
  logic [7:0]        nbytes;
  logic [16:0]       end_sum;
  logic [4:0]        nib_hi, nib_lo;
  logic [IdxW-1:0]   commit_idx;
  logic              complete_q, complete_d, refused;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle);

  assign complete_q = (exp_q != '0) && (seen_total_q >= exp_q);
  assign complete_d = (exp_d != '0) && (seen_total_d >= exp_d);

  assign nbytes  = count_q[8:1];
  assign end_sum = {1'b0, off_q} + 17'(nbytes);
  assign hdr_bad = (total_q == '0) || (total_q > 9'(MaxChunks)) ||
                   (idx_q >= total_q) || count_q[0];
  assign restart   = !hdr_bad && (exp_q != '0) && (exp_q != total_q);
  assign seen_hit  = !restart && seen_rd_q;
  assign too_large = end_sum > 17'(PayloadBytes);
  assign need_wipe = (req_q == ReqReset) || ((req_q == ReqHeader) && restart);
  assign nib_hi    = hex_nibble(hi_q);
  assign nib_lo    = hex_nibble(lo_q);
  assign refused   = (seen_total_q == '0) || !complete_q ||
                     (off_q >= {1'b0, len_q}) || ({1'b0, off_q} >= 17'(PayloadBytes));

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    seen_total_d = seen_total_q;
    exp_d        = exp_q;
    len_d        = len_q;
    open_d       = open_q;
    open_idx_d   = open_idx_q;
    wp_d         = wp_q;
    pairs_d      = pairs_q;
    cend_d       = cend_q;
    out_valid_d  = out_valid_q && out_stall_i;
    rd_ok_d      = rd_ok_q;
    wiped_d      = wiped_q;
    status_d     = StsOk;
    restarted_d  = 1'b0;
    rbyte_d      = '0;
    out_load     = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = wp_q[AddrW-1:0];
    mem_raddr    = off_q[AddrW-1:0];
    mem_wdata    = {nib_hi[3:0], nib_lo[3:0]};
    seen_we      = 1'b0;
    seen_waddr   = open_idx_q;
    seen_wdata   = 1'b1;
    commit       = 1'b0;
    commit_idx   = open_idx_q;

    case (state_q)
      StClear: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_q;
        mem_wdata  = '0;
        seen_we    = 1'b1;
        seen_waddr = clr_q[IdxW-1:0];
        seen_wdata = 1'b0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (req_q == ReqRead) begin
          // store is read here, result formed in StRead from the registered byte
          mem_re  = !refused;
          rd_ok_d = !refused;
          state_d = StRead;
        end else if (need_wipe && !wiped_q) begin
          // seen map is cleared before the request goes on
          state_d = StWipe;
        end else if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          wiped_d     = 1'b0;
          state_d     = StIdle;
          case (req_q)
            ReqHeader: begin
              open_d = 1'b0;
              if (hdr_bad) begin
                status_d = StsBadHeader;
              end else begin
                exp_d = total_q;
                if (restart) begin
                  seen_total_d = '0;
                  len_d        = '0;
                  restarted_d  = 1'b1;
                end
                if (seen_hit) begin
                  status_d = StsDuplicate;
                end else if (too_large) begin
                  status_d = StsTooLarge;
                end else begin
                  open_idx_d = idx_q[IdxW-1:0];
                  commit_idx = idx_q[IdxW-1:0];
                  wp_d       = off_q[LenW-1:0];
                  pairs_d    = nbytes;
                  cend_d     = end_sum[LenW-1:0];
                  open_d     = 1'b1;
                  // empty chunk commits at once
                  if (nbytes == '0) begin
                    commit   = 1'b1;
                    status_d = StsCommitted;
                  end
                end
              end
            end
            ReqPair: begin
              if (!open_q) begin
                status_d = StsNoChunk;
              end else if (nib_hi[4] || nib_lo[4]) begin
                open_d   = 1'b0;
                status_d = StsBadDigit;
              end else begin
                mem_we  = (17'(wp_q) < 17'(PayloadBytes));
                wp_d    = wp_q + 1'b1;
                pairs_d = (pairs_q != '0) ? pairs_q - 1'b1 : '0;
                if (pairs_d == '0) begin
                  commit   = 1'b1;
                  status_d = StsCommitted;
                end
              end
            end
            ReqReset: begin
              seen_total_d = '0;
              len_d        = '0;
              exp_d        = '0;
              open_d       = 1'b0;
            end
            default: begin
            end
          endcase
          if (commit) begin
            seen_we      = 1'b1;
            seen_waddr   = commit_idx;
            seen_total_d = seen_total_d + 1'b1;
            if (cend_d > len_d) begin
              len_d = cend_d;
            end
            open_d = 1'b0;
          end
        end
      end
      StWipe: begin
        seen_we    = 1'b1;
        seen_waddr = clr_q[IdxW-1:0];
        seen_wdata = 1'b0;
        clr_d      = clr_q + 1'b1;
        if (clr_q[IdxW-1:0] == '1) begin
          clr_d   = '0;
          wiped_d = 1'b1;
          state_d = StExec;
        end
      end
      StRead: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
          status_d    = rd_ok_q ? StsOk : StsReadRefused;
          rbyte_d     = rd_ok_q ? rd_q : '0;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      clr_q        <= '0;
      seen_total_q <= '0;
      exp_q        <= '0;
      len_q        <= '0;
      open_q       <= 1'b0;
      open_idx_q   <= '0;
      wp_q         <= '0;
      pairs_q      <= '0;
      cend_q       <= '0;
      out_valid_q  <= 1'b0;
      rd_ok_q      <= 1'b0;
      wiped_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      seen_total_q <= seen_total_d;
      exp_q        <= exp_d;
      len_q        <= len_d;
      open_q       <= open_d;
      open_idx_q   <= open_idx_d;
      wp_q         <= wp_d;
      pairs_q      <= pairs_d;
      cend_q       <= cend_d;
      out_valid_q  <= out_valid_d;
      rd_ok_q      <= rd_ok_d;
      wiped_q      <= wiped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_e'(req_type_i);
      idx_q   <= chunk_index_i;
      total_q <= chunk_total_i;
      off_q   <= byte_offset_i;
      count_q <= hex_char_count_i;
      hi_q    <= hex_high_char_i;
      lo_q    <= hex_low_char_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q    <= status_d;
      restarted_q <= restarted_d;
      rbyte_q     <= rbyte_d;
      res_seen_q  <= seen_total_d;
      res_exp_q   <= exp_d;
      res_len_q   <= len_d;
      res_done_q  <= complete_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      payload_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= payload_mem[mem_raddr];
    end
  end

  // entry of a header is fetched as the request is accepted
  always_ff @(posedge clk_i) begin
    if (seen_we) begin
      seen_mem[seen_waddr] <= seen_wdata;
    end
    if (accept) begin
      seen_rd_q <= seen_mem[chunk_index_i[IdxW-1:0]];
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign chunks_received_o    = res_seen_q;
  assign chunks_expected_o    = res_exp_q;
  assign payload_length_o     = res_len_q;
  assign transfer_complete_o  = res_done_q;
  assign transfer_restarted_o = restarted_q;
  assign read_byte_o          = rbyte_q;

  `CRE_ASSERT_ALWAYS(a_no_accept_while_clearing, clk_i, (state_q == StClear) |-> in_stall_o)
  `CRE_ASSERT(a_accept_goes_exec, clk_i, rst_ni, accept |=> (state_q == StExec))
  `CRE_ASSERT(a_open_chunk_consistent, clk_i, rst_ni,
    open_q |-> ((16'(wp_q) + 16'(pairs_q)) == 16'(cend_q)) && (pairs_q != '0))
  `CRE_ASSERT(a_complete_result, clk_i, rst_ni,
    (out_valid_o && transfer_complete_o) |->
      ((chunks_expected_o != '0) && (chunks_received_o >= chunks_expected_o)))

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cre_pkg::*;

  localparam int WatchdogLimit = 100000;
  localparam int RandomTarget  = 1225;

  typedef struct {
    req_e        kind;
    logic [8:0]  idx;
    logic [8:0]  total;
    logic [15:0] offset;
    logic [8:0]  chars;
    logic [7:0]  hi;
    logic [7:0]  lo;
    bit          drain;
  } request_t;

  typedef struct {
    status_e     status;
    logic [8:0]  received;
    logic [8:0]  expected;
    logic [14:0] length;
    logic        complete;
    logic        restarted;
    logic [7:0]  rbyte;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  req_type_i;
  logic [8:0]  chunk_index_i;
  logic [8:0]  chunk_total_i;
  logic [15:0] byte_offset_i;
  logic [8:0]  hex_char_count_i;
  logic [7:0]  hex_high_char_i;
  logic [7:0]  hex_low_char_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [8:0]  chunks_received_o;
  logic [8:0]  chunks_expected_o;
  logic [14:0] payload_length_o;
  logic        transfer_complete_o;
  logic        transfer_restarted_o;
  logic [7:0]  read_byte_o;

  chunk_reassembly_engine_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .req_type_i          (req_type_i),
    .chunk_index_i       (chunk_index_i),
    .chunk_total_i       (chunk_total_i),
    .byte_offset_i       (byte_offset_i),
    .hex_char_count_i    (hex_char_count_i),
    .hex_high_char_i     (hex_high_char_i),
    .hex_low_char_i      (hex_low_char_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .chunks_received_o   (chunks_received_o),
    .chunks_expected_o   (chunks_expected_o),
    .payload_length_o    (payload_length_o),
    .transfer_complete_o (transfer_complete_o),
    .transfer_restarted_o(transfer_restarted_o),
    .read_byte_o         (read_byte_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // engine state as the predictor tracks it
  logic [7:0]  byte_mem [PayloadBytes];
  bit          seen_bits [MaxChunks];
  logic [8:0]  rx_count;
  logic [8:0]  tot_exp;
  logic [14:0] len_mark;
  logic [14:0] wr_ptr;
  logic [7:0]  left_pairs;
  logic [14:0] end_mark;
  logic [7:0]  open_idx;
  bit          chunk_open;

  request_t pending[$];
  result_t  results_due[$];
  request_t cur;
  bit       req_taken;
  int       gap_left;
  int       stall_left;
  int       stall_roll;
  bit       long_hold_done;
  int       idle_cycles;
  int       cycle_count;
  int       reqs_taken;
  int       results_seen;
  int       reads_served;
  int       errors;
  int       status_hits [8];
  int       restarts;

  function automatic int digit_value(logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return ch - "0";
    if (ch >= "a" && ch <= "f") return ch - "a" + 10;
    if (ch >= "A" && ch <= "F") return ch - "A" + 10;
    return -1;
  endfunction

  function automatic void wipe_progress();
    foreach (seen_bits[i]) seen_bits[i] = 1'b0;
    rx_count = '0;
    len_mark = '0;
  endfunction

  function automatic void commit_open_chunk();
    seen_bits[open_idx] = 1'b1;
    rx_count++;
    if (end_mark > len_mark) len_mark = end_mark;
    chunk_open = 1'b0;
  endfunction

  function automatic result_t apply_request(request_t r);
    result_t     res;
    int          hi_v;
    int          lo_v;
    logic [7:0]  nbytes;
    logic [16:0] span_end;
    res.status    = StsOk;
    res.restarted = 1'b0;
    res.rbyte     = 8'h00;
    case (r.kind)
      ReqHeader: begin
        // any header drops a chunk in progress
        chunk_open = 1'b0;
        if (r.total == 0 || r.total > MaxChunks || r.idx >= r.total || r.chars[0]) begin
          res.status = StsBadHeader;
        end else begin
          nbytes = r.chars[8:1];
          if (tot_exp == 0) begin
            tot_exp = r.total;
          end else if (tot_exp != r.total) begin
            wipe_progress();
            tot_exp = r.total;
            res.restarted = 1'b1;
          end
          span_end = r.offset + nbytes;
          if (seen_bits[r.idx[7:0]]) begin
            res.status = StsDuplicate;
          end else if (span_end > PayloadBytes) begin
            res.status = StsTooLarge;
          end else begin
            open_idx   = r.idx[7:0];
            wr_ptr     = r.offset[14:0];
            left_pairs = nbytes;
            end_mark   = span_end[14:0];
            chunk_open = 1'b1;
            if (nbytes == 0) begin
              commit_open_chunk();
              res.status = StsCommitted;
            end
          end
        end
      end
      ReqPair: begin
        if (!chunk_open) begin
          res.status = StsNoChunk;
        end else begin
          hi_v = digit_value(r.hi);
          lo_v = digit_value(r.lo);
          if (hi_v < 0 || lo_v < 0) begin
            chunk_open = 1'b0;
            res.status = StsBadDigit;
          end else begin
            byte_mem[wr_ptr[13:0]] = 8'(hi_v * 16 + lo_v);
            wr_ptr++;
            if (left_pairs > 0) left_pairs--;
            if (left_pairs == 0) begin
              commit_open_chunk();
              res.status = StsCommitted;
            end
          end
        end
      end
      ReqReset: begin
        wipe_progress();
        tot_exp    = '0;
        chunk_open = 1'b0;
      end
      default: begin
        if (rx_count == 0 || !(tot_exp != 0 && rx_count >= tot_exp) ||
            r.offset >= len_mark || r.offset >= PayloadBytes) begin
          res.status = StsReadRefused;
        end else begin
          res.rbyte = byte_mem[r.offset[13:0]];
          reads_served++;
        end
      end
    endcase
    res.received = rx_count;
    res.expected = tot_exp;
    res.length   = len_mark;
    res.complete = (tot_exp != 0 && rx_count >= tot_exp);
    return res;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // fields that the request type does not use carry random values
  function automatic request_t scrambled(req_e kind);
    request_t r;
    r.kind   = kind;
    r.idx    = 9'($urandom);
    r.total  = 9'($urandom);
    r.offset = 16'($urandom);
    r.chars  = 9'($urandom);
    r.hi     = 8'($urandom);
    r.lo     = 8'($urandom);
    r.drain  = 1'b0;
    return r;
  endfunction

  function automatic void push_header(int idx, int total, int off, int chars);
    request_t r;
    r        = scrambled(ReqHeader);
    r.idx    = 9'(idx);
    r.total  = 9'(total);
    r.offset = 16'(off);
    r.chars  = 9'(chars);
    pending.push_back(r);
  endfunction

  function automatic void push_pair(logic [7:0] hi, logic [7:0] lo);
    request_t r;
    r    = scrambled(ReqPair);
    r.hi = hi;
    r.lo = lo;
    pending.push_back(r);
  endfunction

  function automatic void push_read(int off);
    request_t r;
    r        = scrambled(ReqRead);
    r.offset = 16'(off);
    pending.push_back(r);
  endfunction

  function automatic logic [7:0] good_digit();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  function automatic logic [7:0] bad_digit();
    logic [7:0] c;
    do c = 8'($urandom); while (digit_value(c) >= 0);
    return c;
  endfunction

  // one transfer: shuffled chunks, pairs with random content, a little trouble
  task automatic queue_transfer(bit big);
    int total;
    int span;
    int base;
    int k;
    int n;
    int pick;
    int tmp;
    bit dropped;
    bit first;
    int order[$];
    int done_list[$];
    int offs [MaxChunks];
    int sizes [MaxChunks];
    total = big ? MaxChunks
                : ($urandom_range(0, 99) < 75 ? $urandom_range(1, 6) : $urandom_range(7, 24));
    span = 0;
    for (k = 0; k < total; k++) begin
      sizes[k] = big ? $urandom_range(0, 1)
                     : ($urandom_range(0, 99) < 85 ? $urandom_range(0, 12)
                                                   : $urandom_range(13, 40));
      offs[k] = span;
      span += sizes[k];
    end
    base = ($urandom_range(0, 99) < 75) ? 0 : $urandom_range(0, PayloadBytes - span);
    for (k = 0; k < total; k++) begin
      offs[k] += base;
      order.push_back(k);
    end
    for (k = total - 1; k > 0; k--) begin
      n = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[n];
      order[n] = tmp;
    end
    first = 1'b1;
    while (order.size() != 0) begin
      k = order.pop_front();
      pick = $urandom_range(0, 99);
      if (pick < 2 && !big) return;
      if (pick < 5) begin
        pick = $urandom_range(0, 2);
        pending.push_back(scrambled(pick == 2 ? ReqRead : req_e'(pick)));
      end else if (pick < 8 && done_list.size() != 0) begin
        push_header(done_list[$urandom_range(0, done_list.size() - 1)], total,
                    $urandom_range(0, PayloadBytes - 1), 2 * $urandom_range(0, 10));
      end
      push_header(k, total, offs[k], 2 * sizes[k]);
      if (first && (big || $urandom_range(0, 99) < 15)) pending[$].drain = 1'b1;
      first = 1'b0;
      dropped = 1'b0;
      for (n = 0; n < sizes[k] && !dropped; n++) begin
        pick = $urandom_range(0, 199);
        if (pick < 3) begin
          if (pick[0]) push_pair(bad_digit(), good_digit());
          else push_pair(good_digit(), bad_digit());
          dropped = 1'b1;
        end else if (pick < 5) begin
          // index past the total: rejected, and the open chunk is lost
          push_header(total + $urandom_range(0, 10), total, 0, 2);
          dropped = 1'b1;
        end else begin
          push_pair(good_digit(), good_digit());
        end
      end
      if (dropped) order.push_back(k);
      else done_list.push_back(k);
    end
    for (n = $urandom_range(3, 10); n > 0; n--) begin
      push_read((span != 0 && $urandom_range(0, 3) != 0) ? base + $urandom_range(0, span - 1)
                                                        : $urandom_range(0, 65535));
    end
    if ($urandom_range(0, 99) < 45) pending.push_back(scrambled(ReqReset));
  endtask

  function automatic int send_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if ((reqs_taken / 150) % 4 == 1 || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (req_taken) begin
        req_taken = 1'b0;
        gap_left = send_gap();
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending.size() == 0 || (pending[0].drain && results_due.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else begin
        cur = pending.pop_front();
        req_type_i       <= cur.kind;
        chunk_index_i    <= cur.idx;
        chunk_total_i    <= cur.total;
        byte_offset_i    <= cur.offset;
        hex_char_count_i <= cur.chars;
        hex_high_char_i  <= cur.hi;
        hex_low_char_i   <= cur.lo;
        in_valid_i       <= 1'b1;
      end
    end
  end

  // result receiver stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && results_seen >= 300) begin
        long_hold_done = 1'b1;
        stall_left = 600;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_roll = $urandom_range(0, 99);
        if ((cycle_count / 400) % 4 == 2 || stall_roll < 70) begin
          out_stall_i <= 1'b0;
        end else begin
          out_stall_i <= 1'b1;
          stall_left = (stall_roll < 95) ? $urandom_range(0, 2) : $urandom_range(5, 40);
        end
      end
    end
  end

  // result checking, request acceptance and watchdog
  always @(posedge clk_i) begin
    result_t want;
    cycle_count++;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (results_due.size() == 0) begin
        $display("%0t: result with no request outstanding: expected none, actual status %0d",
                 $time, status_o);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("status", want.status, status_o);
        check_field("chunks_received", want.received, chunks_received_o);
        check_field("chunks_expected", want.expected, chunks_expected_o);
        check_field("payload_length", want.length, payload_length_o);
        check_field("transfer_complete", want.complete, transfer_complete_o);
        check_field("transfer_restarted", want.restarted, transfer_restarted_o);
        check_field("read_byte", want.rbyte, read_byte_o);
        status_hits[status_o]++;
        if (transfer_restarted_o) restarts++;
      end
    end
    if (in_valid_i && !in_stall_o) begin
      results_due.push_back(apply_request(cur));
      req_taken = 1'b1;
      reqs_taken++;
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, results_due.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    out_stall_i      = 1'b0;
    req_type_i       = ReqHeader;
    chunk_index_i    = '0;
    chunk_total_i    = '0;
    byte_offset_i    = '0;
    hex_char_count_i = '0;
    hex_high_char_i  = '0;
    hex_low_char_i   = '0;
    foreach (byte_mem[i]) byte_mem[i] = 8'h00;
    wipe_progress();
    tot_exp    = '0;
    wr_ptr     = '0;
    left_pairs = '0;
    end_mark   = '0;
    open_idx   = '0;
    chunk_open = 1'b0;

    // directed corners
    push_read(0);
    push_pair("0", "0");
    push_header(0, 0, 0, 2);
    push_header(0, MaxChunks + 1, 0, 2);
    push_header(511, 511, 65535, 511);
    push_header(5, 5, 0, 2);
    push_header(0, 2, 0, 3);
    push_header(0, 2, 65535, 2);
    push_header(0, 2, PayloadBytes - 4, 0);
    push_header(0, 2, 0, 4);
    push_header(1, 2, PayloadBytes - 1, 2);
    push_pair("F", "f");
    push_read(PayloadBytes - 1);
    push_read(PayloadBytes);
    push_read(0);
    push_header(2, 3, 0, 6);
    push_pair("A", "9");
    push_pair("g", "0");
    push_pair("0", "1");
    push_header(0, 3, 8, 4);
    push_pair("a", "F");
    push_header(7, 3, 0, 2);
    push_pair("9", "/");
    push_header(MaxChunks - 1, MaxChunks, PayloadBytes - 255, 510);
    pending.push_back(scrambled(ReqReset));

    queue_transfer(1'b1);
    while (pending.size() < RandomTarget) queue_transfer(1'b0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending.size() != 0 || in_valid_i || results_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d requests checked, %0d commits, %0d restarts, %0d reads served",
             reqs_taken, status_hits[StsCommitted], restarts, reads_served);
    $display("rejects: %0d header, %0d duplicate, %0d oversize, %0d digit, %0d stray, %0d read",
             status_hits[StsBadHeader], status_hits[StsDuplicate], status_hits[StsTooLarge],
             status_hits[StsBadDigit], status_hits[StsNoChunk], status_hits[StsReadRefused]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/cre_pkg.sv
hdl/chunk_reassembly_engine_core.sv
dv/testbench.sv
